@@ rtl/burst_receiver_protocol_fsm_defines.svh @@
// ----------------------------------------------------------------------------
// Burst receiver assertion macros
// Shared property macros for the burst receiver modules; they compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BURST_RECEIVER_PROTOCOL_FSM_DEFINES_SVH
`define BURST_RECEIVER_PROTOCOL_FSM_DEFINES_SVH

`ifndef SYNTHESIS
`define BRP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("burst receiver assertion failed");
`define BRP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("burst receiver assertion failed");
`else
`define BRP_ASSERT_IMP(lbl, ante, cons)
`define BRP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ rtl/brp_pkg.sv @@
// ----------------------------------------------------------------------------
// Burst receiver package
// Types, codes and constants shared by the burst receiver modules.
// ----------------------------------------------------------------------------
package brp_pkg;

  localparam int unsigned MAX_PAYLOAD = 256;
  localparam int unsigned LEN_W       = 9;

  localparam int unsigned IN_TDATA_W  = 120;
  localparam int unsigned OUT_TDATA_W = 184;

  localparam int unsigned DIV_NUM_W = 39;
  localparam int unsigned DIV_DEN_W = 32;
  localparam int unsigned DIV_Q_W   = 9;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_Q_W + 1);

  localparam logic [7:0] CH_W = 8'h57;
  localparam logic [7:0] CH_O = 8'h4F;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [6:0] PCT_SCALE = 7'd100;

  typedef enum logic [2:0] {
    EV_TX_DONE   = 3'd0,
    EV_RX_PACKET = 3'd1,
    EV_RX_TIMEOUT = 3'd2,
    EV_CRC_ERROR = 3'd3,
    EV_ABORTED   = 3'd4,
    EV_LOCKED    = 3'd5,
    EV_UNLOCKED  = 3'd6,
    EV_START     = 3'd7
  } ev_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LISTEN = 3'd1,
    PH_ACK    = 3'd2,
    PH_DATA   = 3'd3,
    PH_RESULT = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ACT_NONE         = 3'd0,
    ACT_LISTEN_WOR   = 3'd1,
    ACT_SEND_ACK     = 3'd2,
    ACT_LISTEN_DATA  = 3'd3,
    ACT_DELIVER      = 3'd4,
    ACT_DELIVER_LAST = 3'd5,
    ACT_SEND_RESULT  = 3'd6,
    ACT_BAD_HEADER   = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_MUL,
    CS_DIVGO,
    CS_DIV,
    CS_COMMIT
  } cs_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_go;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
  } dp_stat_t;

endpackage

@@ rtl/brp_divider.sv @@
// ----------------------------------------------------------------------------
// Burst receiver shared divider
// Restoring divider that produces one quotient bit per cycle. The dividend
// shifted right by the quotient width must be below the divisor.
// ----------------------------------------------------------------------------
module brp_divider (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [brp_pkg::DIV_NUM_W-1:0]   dividend,
  input  logic [brp_pkg::DIV_DEN_W-1:0]   divisor,
  output logic                            busy,
  output logic [brp_pkg::DIV_Q_W-1:0]     quotient
);

  logic                          run_r;
  logic                          run_nxt;
  logic [brp_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [brp_pkg::DIV_CNT_W-1:0] cnt_nxt;
  logic [brp_pkg::DIV_DEN_W-1:0] rem_r;
  logic [brp_pkg::DIV_DEN_W-1:0] rem_nxt;
  logic [brp_pkg::DIV_Q_W-1:0]   num_r;
  logic [brp_pkg::DIV_Q_W-1:0]   num_nxt;
  logic [brp_pkg::DIV_Q_W-1:0]   q_r;
  logic [brp_pkg::DIV_Q_W-1:0]   q_nxt;
  logic [brp_pkg::DIV_DEN_W-1:0] den_r;
  logic [brp_pkg::DIV_DEN_W-1:0] den_nxt;
  logic [brp_pkg::DIV_DEN_W:0]   trial;
  logic                          ge;

  always_comb begin
    trial   = {rem_r, num_r[brp_pkg::DIV_Q_W-1]};
    ge      = trial >= {1'b0, den_r};
    run_nxt = run_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    num_nxt = num_r;
    q_nxt   = q_r;
    den_nxt = den_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = brp_pkg::DIV_CNT_W'(brp_pkg::DIV_Q_W);
      rem_nxt = brp_pkg::DIV_DEN_W'(dividend[brp_pkg::DIV_NUM_W-1:brp_pkg::DIV_Q_W]);
      num_nxt = dividend[brp_pkg::DIV_Q_W-1:0];
      den_nxt = divisor;
    end else if (run_r) begin
      rem_nxt = ge ? brp_pkg::DIV_DEN_W'(trial - {1'b0, den_r})
                   : trial[brp_pkg::DIV_DEN_W-1:0];
      num_nxt = {num_r[brp_pkg::DIV_Q_W-2:0], 1'b0};
      q_nxt   = {q_r[brp_pkg::DIV_Q_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == brp_pkg::DIV_CNT_W'(1)) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign busy     = run_r;
  assign quotient = q_r;

endmodule

@@ rtl/brp_datapath.sv @@
// ----------------------------------------------------------------------------
// Burst receiver datapath
// Holds the event fields, the protocol state and burst statistics, the
// multipliers and the shared divider, and builds the result beat.
// ----------------------------------------------------------------------------
module brp_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  brp_pkg::dp_cmd_t                  cmd,
  output brp_pkg::dp_stat_t                 stat,
  input  logic [2:0]                        in_tuser,
  input  logic [brp_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic [2:0]                        out_tuser,
  output logic [brp_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  brp_pkg::ev_t           ev_r;
  logic [63:0]            head_r;
  logic [8:0]             len_r;
  logic signed [8:0]      rssi_r;
  logic [31:0]            foff_r;

  brp_pkg::phase_t        phase_r;
  brp_pkg::phase_t        phase_nxt;
  logic [31:0]            size_r;
  logic [31:0]            size_nxt;
  logic [7:0]             rate_r;
  logic [7:0]             rate_nxt;
  logic [31:0]            offs_r;
  logic [31:0]            offs_nxt;
  logic [31:0]            bytes_r;
  logic [31:0]            bytes_nxt;
  logic signed [8:0]      mean_r;
  logic signed [8:0]      mean_nxt;
  logic [15:0]            good_r;
  logic [15:0]            good_nxt;
  logic [15:0]            err_r;
  logic [15:0]            err_nxt;
  logic [6:0]             pct_r;
  logic [6:0]             pct_nxt;

  logic signed [25:0]     prod_r;
  logic [38:0]            loss_prod_r;
  logic                   acc_neg_r;
  logic signed [25:0]     acc;
  logic [25:0]            acc_mag;
  logic [8:0]             len_in;

  logic [brp_pkg::DIV_NUM_W-1:0] div_num;
  logic [brp_pkg::DIV_DEN_W-1:0] div_den;
  logic [brp_pkg::DIV_Q_W-1:0]   div_q;
  logic                          div_busy;
  logic [9:0]                    q_signed;

  brp_pkg::action_t       act;
  logic                   bad_header;
  logic [15:0]            pidx;
  logic [7:0]             dlen;
  logic [32:0]            byte_sum;

  logic [2:0]                        out_tuser_r;
  logic [brp_pkg::OUT_TDATA_W-1:0]   out_tdata_r;

  assign len_in = (in_tdata[72:64] > brp_pkg::LEN_W'(brp_pkg::MAX_PAYLOAD))
                  ? brp_pkg::LEN_W'(brp_pkg::MAX_PAYLOAD) : in_tdata[72:64];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ev_r   <= brp_pkg::ev_t'(in_tuser);
      head_r <= in_tdata[63:0];
      len_r  <= len_in;
      rssi_r <= $signed(in_tdata[81:73]);
      foff_r <= in_tdata[113:82];
    end
    if (cmd.mul) begin
      prod_r      <= mean_r * $signed({1'b0, good_r});
      loss_prod_r <= 39'(size_r - bytes_r) * 39'(brp_pkg::PCT_SCALE);
    end
    if (cmd.div_go) begin
      acc_neg_r <= acc[25];
    end
  end

  always_comb begin
    acc     = prod_r + 26'(rssi_r);
    acc_mag = acc[25] ? 26'(-acc) : acc;
    if (ev_r == brp_pkg::EV_UNLOCKED) begin
      div_num = loss_prod_r;
      div_den = size_r;
    end else begin
      div_num = brp_pkg::DIV_NUM_W'(acc_mag[24:0]);
      div_den = brp_pkg::DIV_DEN_W'(16'(good_r + 16'd1));
    end
  end

  brp_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign stat.div_busy = div_busy;
  assign q_signed      = acc_neg_r ? 10'(-{1'b0, div_q}) : {1'b0, div_q};

  always_comb begin
    phase_nxt  = phase_r;
    size_nxt   = size_r;
    rate_nxt   = rate_r;
    offs_nxt   = offs_r;
    bytes_nxt  = bytes_r;
    mean_nxt   = mean_r;
    good_nxt   = good_r;
    err_nxt    = err_r;
    pct_nxt    = pct_r;
    act        = brp_pkg::ACT_NONE;
    bad_header = 1'b0;
    pidx       = '0;
    dlen       = '0;
    byte_sum   = {1'b0, bytes_r} + 33'(len_r);
    unique case (ev_r)
      brp_pkg::EV_TX_DONE: begin
        if (phase_r == brp_pkg::PH_ACK) begin
          bytes_nxt = '0;
          mean_nxt  = '0;
          good_nxt  = '0;
          err_nxt   = '0;
          phase_nxt = brp_pkg::PH_DATA;
          act       = brp_pkg::ACT_LISTEN_DATA;
        end else if (phase_r == brp_pkg::PH_RESULT) begin
          phase_nxt = brp_pkg::PH_LISTEN;
        end
      end
      brp_pkg::EV_RX_PACKET: begin
        if (phase_r == brp_pkg::PH_LISTEN) begin
          if (head_r[7:0] == brp_pkg::CH_W && head_r[15:8] == brp_pkg::CH_O &&
              head_r[23:16] == brp_pkg::CH_R) begin
            size_nxt  = head_r[55:24];
            rate_nxt  = head_r[63:56];
            offs_nxt  = foff_r;
            phase_nxt = brp_pkg::PH_ACK;
            act       = brp_pkg::ACT_SEND_ACK;
          end else begin
            bad_header = 1'b1;
          end
        end else if (phase_r == brp_pkg::PH_DATA) begin
          pidx      = head_r[15:0];
          dlen      = (len_r >= 9'd2) ? 8'(len_r - 9'd2) : 8'd0;
          bytes_nxt = byte_sum[32] ? 32'hFFFF_FFFF : byte_sum[31:0];
          if (good_r != 16'hFFFF) begin
            good_nxt = good_r + 16'd1;
            mean_nxt = $signed(q_signed[8:0]);
          end
          act = (bytes_nxt == size_r) ? brp_pkg::ACT_DELIVER_LAST : brp_pkg::ACT_DELIVER;
        end
      end
      brp_pkg::EV_CRC_ERROR: begin
        if (phase_r == brp_pkg::PH_DATA && err_r != 16'hFFFF) begin
          err_nxt = err_r + 16'd1;
        end
      end
      brp_pkg::EV_ABORTED: begin
        phase_nxt = brp_pkg::PH_LISTEN;
      end
      brp_pkg::EV_UNLOCKED: begin
        if (phase_r == brp_pkg::PH_DATA) begin
          pct_nxt   = (size_r == 32'd0 || bytes_r > size_r) ? 7'd0 : div_q[6:0];
          phase_nxt = brp_pkg::PH_RESULT;
        end
      end
      brp_pkg::EV_START: begin
        size_nxt  = '0;
        rate_nxt  = '0;
        offs_nxt  = '0;
        bytes_nxt = '0;
        mean_nxt  = '0;
        good_nxt  = '0;
        err_nxt   = '0;
        pct_nxt   = '0;
        phase_nxt = brp_pkg::PH_LISTEN;
      end
      brp_pkg::EV_RX_TIMEOUT, brp_pkg::EV_LOCKED: begin
      end
    endcase
    priority if (phase_nxt == brp_pkg::PH_LISTEN) begin
      act = bad_header ? brp_pkg::ACT_BAD_HEADER : brp_pkg::ACT_LISTEN_WOR;
    end else if (phase_nxt == brp_pkg::PH_RESULT) begin
      act = brp_pkg::ACT_SEND_RESULT;
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= brp_pkg::PH_IDLE;
      size_r  <= '0;
      rate_r  <= '0;
      offs_r  <= '0;
      bytes_r <= '0;
      mean_r  <= '0;
      good_r  <= '0;
      err_r   <= '0;
      pct_r   <= '0;
    end else if (cmd.commit) begin
      phase_r <= phase_nxt;
      size_r  <= size_nxt;
      rate_r  <= rate_nxt;
      offs_r  <= offs_nxt;
      bytes_r <= bytes_nxt;
      mean_r  <= mean_nxt;
      good_r  <= good_nxt;
      err_r   <= err_nxt;
      pct_r   <= pct_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_tuser_r <= act;
      out_tdata_r <= {5'd0, offs_nxt, rate_nxt, size_nxt, pct_nxt, err_nxt, good_nxt,
                      mean_nxt, bytes_nxt, dlen, pidx, phase_nxt};
    end
  end

  assign out_tuser = out_tuser_r;
  assign out_tdata = out_tdata_r;

endmodule

@@ rtl/brp_ctrl.sv @@
// ----------------------------------------------------------------------------
// Burst receiver controller
// Sequences one event through capture, multiply, division and commit, and
// owns both stream handshakes.
// ----------------------------------------------------------------------------
`include "burst_receiver_protocol_fsm_defines.svh"

module brp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output brp_pkg::dp_cmd_t  cmd,
  input  brp_pkg::dp_stat_t stat
);

  brp_pkg::cs_t state_r;
  brp_pkg::cs_t state_nxt;
  logic         out_tvalid_r;
  logic         out_tvalid_nxt;
  logic         room;

  assign room = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      brp_pkg::CS_IDLE: begin
        if (in_tvalid) begin
          state_nxt = brp_pkg::CS_MUL;
        end
      end
      brp_pkg::CS_MUL: begin
        state_nxt = brp_pkg::CS_DIVGO;
      end
      brp_pkg::CS_DIVGO: begin
        state_nxt = brp_pkg::CS_DIV;
      end
      brp_pkg::CS_DIV: begin
        if (!stat.div_busy) begin
          state_nxt = brp_pkg::CS_COMMIT;
        end
      end
      brp_pkg::CS_COMMIT: begin
        if (room) begin
          state_nxt = brp_pkg::CS_IDLE;
        end
      end
      default: begin
        state_nxt = brp_pkg::CS_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      brp_pkg::CS_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      brp_pkg::CS_MUL: begin
        cmd.mul = 1'b1;
      end
      brp_pkg::CS_DIVGO: begin
        cmd.div_go = 1'b1;
      end
      brp_pkg::CS_DIV: begin
      end
      brp_pkg::CS_COMMIT: begin
        cmd.commit = room;
      end
      default: begin
      end
    endcase
    out_tvalid_nxt = cmd.commit ? 1'b1 : (out_tvalid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= brp_pkg::CS_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;

  `BRP_ASSERT_NXT(a_accept_to_mul, in_tvalid && in_tready, state_r == brp_pkg::CS_MUL)
  `BRP_ASSERT_NXT(a_divgo_starts_div, state_r == brp_pkg::CS_DIVGO, stat.div_busy)
  `BRP_ASSERT_NXT(a_div_end_commits, state_r == brp_pkg::CS_DIV && !stat.div_busy, state_r == brp_pkg::CS_COMMIT)
  `BRP_ASSERT_NXT(a_commit_shows_beat, cmd.commit, out_tvalid_r)
  `BRP_ASSERT_IMP(a_no_div_at_commit, state_r == brp_pkg::CS_COMMIT, !stat.div_busy)

endmodule

@@ rtl/burst_receiver_protocol_fsm.sv @@
// Each input beat is one radio event and gives exactly one result beat. An
// event is accepted in the waiting state and then passes through the states
// in order: a multiply state, a state that loads the shared divider, a divide
// state that waits while its nine quotient steps run and a commit state that
// commits the state and loads the result into the output register; then the
// block is back in the waiting state and can accept the next event. A new
// event is accepted while an earlier result still waits at the output; only
// when a result cannot be loaded because the previous one has not been taken
// does the block hold its next event longer.
// ----------------------------------------------------------------------------
// Burst receiver protocol state machine
// Receiver end of a wake-up and burst exchange: checks the wake-up header,
// counts data packets and CRC errors, keeps a running mean of RSSI and works
// out the loss percentage when the radio unlocks.
// ----------------------------------------------------------------------------
module burst_receiver_protocol_fsm (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // mode [2:0]
  input  logic [2:0]                        in_tuser,
  // payload_head [63:0], rx_size [72:64], rssi [81:73], freq_offset [113:82]
  input  logic [brp_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // action [2:0]
  output logic [2:0]                        out_tuser,
  // state_now [2:0], packet_index [18:3], payload_length [26:19],
  // bytes_received [58:27], rssi_average [67:59], packets_ok [83:68],
  // crc_errors [99:84], loss_percent [106:100], expected_size [138:107],
  // bitrate_code [146:139], offset_held [178:147]
  output logic [brp_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  brp_pkg::dp_cmd_t  cmd;
  brp_pkg::dp_stat_t stat;

  brp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  brp_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata)
  );

endmodule

@@ dv/brp_event_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Burst receiver event checker
// Watches both stream channels of the burst receiver. Every accepted radio
// event is run through a behavioural copy of the receiver state machine. The
// report that results is queued and compared, field by field, with the next
// result beat.
// ----------------------------------------------------------------------------
module brp_event_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [2:0]                       in_tuser,
  input  logic [brp_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [2:0]                       out_tuser,
  input  logic [brp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output int                               fail_count,
  output int                               pending,
  output int                               results_seen
);

  localparam int PRINT_LIMIT = 30;

  typedef struct {
    brp_pkg::action_t action;
    brp_pkg::phase_t  phase;
    logic [15:0]      index;
    logic [7:0]       payload_len;
    logic [31:0]      byte_count;
    logic [8:0]       rssi_avg;
    logic [15:0]      good;
    logic [15:0]      crc;
    logic [6:0]       loss;
    logic [31:0]      size;
    logic [7:0]       rate;
    logic [31:0]      offset;
  } burst_report_t;

  burst_report_t awaited_reports[$];

  brp_pkg::phase_t phase_q;
  logic [31:0]     size_q;
  logic [7:0]      rate_q;
  logic [31:0]     offset_q;
  logic [31:0]     byte_q;
  int              mean_q;
  int              good_q;
  int              crc_q;
  logic [6:0]      loss_q;

  task automatic clear_burst();
    byte_q = '0;
    mean_q = 0;
    good_q = 0;
    crc_q  = 0;
  endtask

  task automatic clear_all();
    clear_burst();
    phase_q  = brp_pkg::PH_IDLE;
    size_q   = '0;
    rate_q   = '0;
    offset_q = '0;
    loss_q   = '0;
  endtask

  task automatic predict_radio_event(input brp_pkg::ev_t ev,
                                     input logic [brp_pkg::IN_TDATA_W-1:0] beat,
                                     output burst_report_t rep);
    logic [63:0]       head;
    int                len;
    logic signed [8:0] rssi_raw;
    int                rssi_v;
    logic [31:0]       foff;
    logic [32:0]       sum;
    longint            acc;
    logic [63:0]       num;
    logic              bad;
    head     = beat[63:0];
    len      = beat[72:64];
    rssi_raw = beat[81:73];
    rssi_v   = rssi_raw;
    foff     = beat[113:82];
    bad      = 1'b0;
    if (len > brp_pkg::MAX_PAYLOAD) len = brp_pkg::MAX_PAYLOAD;
    rep.action      = brp_pkg::ACT_NONE;
    rep.index       = '0;
    rep.payload_len = '0;
    case (ev)
      brp_pkg::EV_TX_DONE: begin
        if (phase_q == brp_pkg::PH_ACK) begin
          clear_burst();
          phase_q    = brp_pkg::PH_DATA;
          rep.action = brp_pkg::ACT_LISTEN_DATA;
        end else if (phase_q == brp_pkg::PH_RESULT) begin
          phase_q = brp_pkg::PH_LISTEN;
        end
      end
      brp_pkg::EV_RX_PACKET: begin
        if (phase_q == brp_pkg::PH_LISTEN) begin
          if (head[7:0] == brp_pkg::CH_W && head[15:8] == brp_pkg::CH_O &&
              head[23:16] == brp_pkg::CH_R) begin
            size_q     = head[55:24];
            rate_q     = head[63:56];
            offset_q   = foff;
            phase_q    = brp_pkg::PH_ACK;
            rep.action = brp_pkg::ACT_SEND_ACK;
          end else begin
            bad = 1'b1;
          end
        end else if (phase_q == brp_pkg::PH_DATA) begin
          sum             = {1'b0, byte_q} + 33'(len);
          byte_q          = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          rep.index       = head[15:0];
          rep.payload_len = (len >= 2) ? 8'(len - 2) : 8'd0;
          if (good_q < 65535) begin
            acc    = longint'(mean_q) * good_q + rssi_v;
            good_q = good_q + 1;
            mean_q = int'(acc / good_q);
          end
          rep.action = (byte_q == size_q) ? brp_pkg::ACT_DELIVER_LAST : brp_pkg::ACT_DELIVER;
        end
      end
      brp_pkg::EV_CRC_ERROR: begin
        if (phase_q == brp_pkg::PH_DATA && crc_q < 65535) crc_q = crc_q + 1;
      end
      brp_pkg::EV_ABORTED: phase_q = brp_pkg::PH_LISTEN;
      brp_pkg::EV_UNLOCKED: begin
        if (phase_q == brp_pkg::PH_DATA) begin
          if (size_q == 0 || byte_q > size_q) begin
            loss_q = '0;
          end else begin
            num    = 64'(size_q - byte_q) * brp_pkg::PCT_SCALE;
            loss_q = 7'(num / size_q);
          end
          phase_q = brp_pkg::PH_RESULT;
        end
      end
      brp_pkg::EV_START: begin
        clear_all();
        phase_q = brp_pkg::PH_LISTEN;
      end
      default: ;
    endcase
    if (phase_q == brp_pkg::PH_LISTEN) begin
      rep.action = bad ? brp_pkg::ACT_BAD_HEADER : brp_pkg::ACT_LISTEN_WOR;
    end else if (phase_q == brp_pkg::PH_RESULT) begin
      rep.action = brp_pkg::ACT_SEND_RESULT;
    end
    rep.phase      = phase_q;
    rep.byte_count = byte_q;
    rep.rssi_avg   = 9'(mean_q);
    rep.good       = 16'(good_q);
    rep.crc        = 16'(crc_q);
    rep.loss       = loss_q;
    rep.size       = size_q;
    rep.rate       = rate_q;
    rep.offset     = offset_q;
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      if (fail_count < PRINT_LIMIT)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      fail_count = fail_count + 1;
    end
  endtask

  always @(posedge clk) begin
    burst_report_t rep;
    if (!rst_n) begin
      clear_all();
      awaited_reports.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        predict_radio_event(brp_pkg::ev_t'(in_tuser), in_tdata, rep);
        awaited_reports.push_back(rep);
      end
      if (out_tvalid && out_tready) begin
        results_seen = results_seen + 1;
        if (awaited_reports.size() == 0) begin
          if (fail_count < PRINT_LIMIT)
            $display("%0t: result beat with no event awaiting it, expected none, got action %0d data %0h",
                     $time, out_tuser, out_tdata);
          fail_count = fail_count + 1;
        end else begin
          rep = awaited_reports.pop_front();
          check_field("action", rep.action, out_tuser);
          check_field("state_now", rep.phase, out_tdata[2:0]);
          check_field("packet_index", rep.index, out_tdata[18:3]);
          check_field("payload_length", rep.payload_len, out_tdata[26:19]);
          check_field("bytes_received", rep.byte_count, out_tdata[58:27]);
          check_field("rssi_average", rep.rssi_avg, out_tdata[67:59]);
          check_field("packets_ok", rep.good, out_tdata[83:68]);
          check_field("crc_errors", rep.crc, out_tdata[99:84]);
          check_field("loss_percent", rep.loss, out_tdata[106:100]);
          check_field("expected_size", rep.size, out_tdata[138:107]);
          check_field("bitrate_code", rep.rate, out_tdata[146:139]);
          check_field("offset_held", rep.offset, out_tdata[178:147]);
        end
      end
    end
    pending = awaited_reports.size();
  end

endmodule

@@ dv/burst_receiver_protocol_fsm_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Burst receiver testbench
// Drives radio events into the burst receiver: a directed opening over the
// field extremes and the corner cases of the protocol, then random wake-up
// and burst exchanges mixed with stray events. Both sides of the stream
// interface pause at random. The checker module judges every result beat.
// ----------------------------------------------------------------------------
module burst_receiver_protocol_fsm_tb;

  localparam int RANDOM_EVENTS = 1550;
  localparam int CYCLE_LIMIT   = 400000;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  wire                              in_tready;
  logic [2:0]                       in_tuser   = '0;
  logic [brp_pkg::IN_TDATA_W-1:0]   in_tdata   = '0;
  wire                              out_tvalid;
  logic                             out_tready = 1'b0;
  wire  [2:0]                       out_tuser;
  wire  [brp_pkg::OUT_TDATA_W-1:0]  out_tdata;

  logic calm         = 1'b0;
  int   events_sent  = 0;
  int   bursts       = 0;
  int   fail_count;
  int   pending;
  int   results_seen;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  burst_receiver_protocol_fsm u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  brp_event_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tuser     (in_tuser),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tuser    (out_tuser),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  always @(negedge clk) out_tready <= calm || ($urandom_range(99, 0) >= 6);

  function automatic logic [63:0] wake_header(input logic [31:0] size, input logic [7:0] rate);
    return {rate, size, brp_pkg::CH_R, brp_pkg::CH_O, brp_pkg::CH_W};
  endfunction

  function automatic logic [8:0] any_rssi();
    logic [8:0] mag;
    mag = 9'($urandom_range(256, 0));
    return -mag;
  endfunction

  task automatic send_event(input brp_pkg::ev_t ev, input logic [63:0] head,
                            input logic [8:0] len, input logic [8:0] rssi,
                            input logic [31:0] foff);
    if (!calm && $urandom_range(99, 0) < 6) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= ev;
    in_tdata  <= brp_pkg::IN_TDATA_W'({foff, rssi, len, head});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    events_sent++;
  endtask

  task automatic send_bare(input brp_pkg::ev_t ev);
    send_event(ev, {$urandom, $urandom}, 9'($urandom), any_rssi(), $urandom);
  endtask

  task automatic send_packet(input logic [8:0] len);
    send_event(brp_pkg::EV_RX_PACKET, {$urandom, $urandom}, len, any_rssi(), $urandom);
  endtask

  task automatic run_burst();
    logic [8:0]  lens[8];
    longint      total;
    logic [31:0] size;
    logic [63:0] head;
    int          n;
    int          pick;
    int          k;
    bursts++;
    send_bare($urandom_range(3, 0) == 0 ? brp_pkg::EV_ABORTED : brp_pkg::EV_START);
    n     = $urandom_range(8, 1);
    total = 0;
    for (k = 0; k < n; k++) begin
      lens[k] = ($urandom_range(9, 0) == 0) ? 9'($urandom) : 9'($urandom_range(40, 0));
      total   = total + ((lens[k] > brp_pkg::MAX_PAYLOAD) ? brp_pkg::MAX_PAYLOAD : lens[k]);
    end
    pick = $urandom_range(99, 0);
    if (pick < 50)      size = 32'(total);
    else if (pick < 65) size = 32'(total) - $urandom_range(20, 1);
    else if (pick < 80) size = 32'(total) + $urandom_range(300, 1);
    else if (pick < 90) size = '0;
    else                size = $urandom;
    if ($urandom_range(99, 0) < 15) begin
      head = wake_header(size, 8'($urandom));
      k    = $urandom_range(2, 0);
      head[8*k +: 8] = head[8*k +: 8] ^ 8'($urandom_range(255, 1));
      send_event(brp_pkg::EV_RX_PACKET, head, 9'($urandom), any_rssi(), $urandom);
    end
    send_event(brp_pkg::EV_RX_PACKET, wake_header(size, 8'($urandom)), 9'($urandom),
               any_rssi(), $urandom);
    if ($urandom_range(99, 0) < 20) send_bare(brp_pkg::ev_t'($urandom_range(6, 2)));
    send_bare(brp_pkg::EV_TX_DONE);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(99, 0) < 15) send_bare(brp_pkg::EV_CRC_ERROR);
      if ($urandom_range(99, 0) < 5)
        send_bare($urandom_range(1, 0) ? brp_pkg::EV_LOCKED : brp_pkg::EV_RX_TIMEOUT);
      send_packet(lens[k]);
    end
    if ($urandom_range(99, 0) < 10) send_packet(9'($urandom_range(40, 0)));
    send_bare($urandom_range(99, 0) < 90 ? brp_pkg::EV_UNLOCKED : brp_pkg::EV_ABORTED);
    if ($urandom_range(99, 0) < 30) send_bare(brp_pkg::EV_RX_TIMEOUT);
    if ($urandom_range(99, 0) < 70) send_bare(brp_pkg::EV_TX_DONE);
  endtask

  initial begin
    int stop_after;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Events before any start, while the receiver is still idle.
    send_bare(brp_pkg::EV_LOCKED);
    send_packet(9'd5);
    send_bare(brp_pkg::EV_TX_DONE);
    send_bare(brp_pkg::EV_START);
    send_bare(brp_pkg::EV_RX_TIMEOUT);
    send_event(brp_pkg::EV_RX_PACKET,
               {8'hFF, 32'd10, brp_pkg::CH_R, brp_pkg::CH_O ^ 8'h01, brp_pkg::CH_W},
               9'd12, 9'd0, '0);
    send_event(brp_pkg::EV_RX_PACKET, wake_header(32'd10, 8'hFF), 9'd20, 9'h100,
               32'h8000_0000);
    send_bare(brp_pkg::EV_CRC_ERROR);
    send_bare(brp_pkg::EV_TX_DONE);
    send_event(brp_pkg::EV_RX_PACKET, '1, 9'd0, 9'h100, 32'h7FFF_FFFF);
    send_event(brp_pkg::EV_RX_PACKET, '0, 9'd1, 9'd0, '0);
    send_bare(brp_pkg::EV_CRC_ERROR);
    send_packet(9'd9);
    send_event(brp_pkg::EV_RX_PACKET, {$urandom, $urandom}, 9'h1FF, 9'h1FF, '1);
    send_bare(brp_pkg::EV_LOCKED);
    // The byte total now exceeds the announced size.
    send_bare(brp_pkg::EV_UNLOCKED);
    send_bare(brp_pkg::EV_RX_TIMEOUT);
    send_bare(brp_pkg::EV_TX_DONE);
    send_event(brp_pkg::EV_RX_PACKET, wake_header(32'd0, 8'h00), 9'd0, 9'd0, '0);
    send_bare(brp_pkg::EV_TX_DONE);
    send_bare(brp_pkg::EV_UNLOCKED);
    send_bare(brp_pkg::EV_ABORTED);
    // The largest size needs the full width of the loss product.
    send_event(brp_pkg::EV_RX_PACKET, wake_header(32'hFFFF_FFFF, 8'h00), 9'd256, 9'd0, '0);
    send_bare(brp_pkg::EV_TX_DONE);
    send_packet(9'd256);
    send_bare(brp_pkg::EV_UNLOCKED);
    send_bare(brp_pkg::EV_START);
    send_event(brp_pkg::EV_RX_PACKET, wake_header(32'd1000, 8'h5A), 9'd0, 9'd0, '0);
    send_bare(brp_pkg::EV_TX_DONE);
    send_packet(9'd300);
    send_bare(brp_pkg::EV_ABORTED);

    stop_after = events_sent + RANDOM_EVENTS;
    while (events_sent < stop_after) begin
      calm = (events_sent >= 700 && events_sent < 1000);
      if ($urandom_range(99, 0) < 8) send_bare(brp_pkg::ev_t'($urandom_range(7, 0)));
      else                           run_burst();
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (40) @(negedge clk);
    $display("Sent %0d radio events: a directed opening, then %0d random burst exchanges %s",
             events_sent, bursts, "mixed with stray events.");
    $display("Checked %0d result beats; %0d field mismatches.", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timed out with %0d results still outstanding.", pending);
    $display("TB_ERROR");
    $finish;
  end

endmodule
